FILE: hdl/efe_pkg.sv
// ----------------------------------------------------------------------------
// efe_pkg: shared types and constants for the escaped frame encoder
// Symbol reset values, register indexes, controller state, the command and
// status groups between controller and datapath, and the reserved-byte test.
// ----------------------------------------------------------------------------
package efe_pkg;

   localparam int BYTE_W    = 8;
   localparam int CSR_IDX_W = 2;

   localparam logic [BYTE_W-1:0] START_SYMBOL_RST  = 8'd170;
   localparam logic [BYTE_W-1:0] ESCAPE_SYMBOL_RST = 8'd204;
   localparam logic [BYTE_W-1:0] END_SYMBOL_RST    = 8'd187;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_START_SYMBOL  = 2'd0,
      CSR_ESCAPE_SYMBOL = 2'd1,
      CSR_END_SYMBOL    = 2'd2
   } csr_index_type;

   typedef enum logic [5:0] {
      ST_COLLECT    = 6'b000001,
      ST_SCAN       = 6'b000010,
      ST_EMIT_START = 6'b000100,
      ST_EMIT_DATA  = 6'b001000,
      ST_EMIT_SUM   = 6'b010000,
      ST_EMIT_END   = 6'b100000
   } state_type;

   typedef enum logic [2:0] {
      SEL_START  = 3'd0,
      SEL_ESCAPE = 3'd1,
      SEL_DATA   = 3'd2,
      SEL_SUM    = 3'd3,
      SEL_END    = 3'd4
   } push_sel_type;

   typedef struct packed {
      logic         accept;      // take the input word into the store
      logic         frame_clear; // drop frame state: count, overflow, sum
      logic         idx_clear;   // rewind pointer, arm all-reserved flag
      logic         idx_inc;
      logic         scan_step;   // fold current entry into all-reserved flag
      logic         push;        // load output register
      push_sel_type push_sel;
      logic         esc_set;
      logic         esc_clear;
   } cmd_type;

   typedef struct packed {
      logic full;        // store holds MAX_PAYLOAD words
      logic almost_full; // one slot left
      logic ovf;
      logic last_idx;    // pointer at final stored word
      logic cur_res;     // word at pointer is reserved
      logic sum_res;     // checksum is reserved
      logic all_res;     // every word scanned so far is reserved
      logic esc;         // escape already sent for current word
      logic out_free;
   } status_type;

   function automatic logic is_reserved(input logic [BYTE_W-1:0] b,
                                        input logic [BYTE_W-1:0] s0,
                                        input logic [BYTE_W-1:0] s1,
                                        input logic [BYTE_W-1:0] s2);
      return (b == s0) || (b == s1) || (b == s2);
   endfunction

endpackage

FILE: hdl/efe_ctrl.sv
// ----------------------------------------------------------------------------
// efe_ctrl: frame encoder controller
// Sequences collection, the full-frame length check and byte emission.
// ----------------------------------------------------------------------------
module efe_ctrl
   import efe_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_payload_last,
   output logic       req_ready,
   input  status_type st,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_COLLECT;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_COLLECT);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_COLLECT: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (req_payload_last) begin
                  if (st.ovf || st.full) begin
                     cmd.frame_clear = 1'b1;
                  end else begin
                     cmd.idx_clear = 1'b1;
                     state_in = st.almost_full ? ST_SCAN : ST_EMIT_START;
                  end
               end
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (st.last_idx) begin
               if (st.all_res && st.cur_res && st.sum_res) begin
                  cmd.frame_clear = 1'b1;
                  state_in = ST_COLLECT;
               end else begin
                  cmd.idx_clear = 1'b1;
                  state_in = ST_EMIT_START;
               end
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         ST_EMIT_START: begin
            if (st.out_free) begin
               cmd.push      = 1'b1;
               cmd.push_sel  = SEL_START;
               cmd.idx_clear = 1'b1;
               cmd.esc_clear = 1'b1;
               state_in = ST_EMIT_DATA;
            end
         end
         ST_EMIT_DATA: begin
            if (st.out_free) begin
               cmd.push = 1'b1;
               if (st.cur_res && !st.esc) begin
                  cmd.push_sel = SEL_ESCAPE;
                  cmd.esc_set  = 1'b1;
               end else begin
                  cmd.push_sel  = SEL_DATA;
                  cmd.esc_clear = 1'b1;
                  if (st.last_idx) begin
                     state_in = ST_EMIT_SUM;
                  end else begin
                     cmd.idx_inc = 1'b1;
                  end
               end
            end
         end
         ST_EMIT_SUM: begin
            if (st.out_free) begin
               cmd.push = 1'b1;
               if (st.sum_res && !st.esc) begin
                  cmd.push_sel = SEL_ESCAPE;
                  cmd.esc_set  = 1'b1;
               end else begin
                  cmd.push_sel  = SEL_SUM;
                  cmd.esc_clear = 1'b1;
                  state_in = ST_EMIT_END;
               end
            end
         end
         ST_EMIT_END: begin
            if (st.out_free) begin
               cmd.push        = 1'b1;
               cmd.push_sel    = SEL_END;
               cmd.frame_clear = 1'b1;
               state_in = ST_COLLECT;
            end
         end
         default: begin
            state_in = ST_COLLECT;
         end
      endcase
   end

endmodule

FILE: hdl/efe_dp.sv
// ----------------------------------------------------------------------------
// efe_dp: frame encoder datapath
// Symbol registers, payload store, running checksum, pointer and the output
// word register.
// ----------------------------------------------------------------------------
module efe_dp
   import efe_pkg::*;
#(
   parameter int MAX_PAYLOAD = 8
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic [BYTE_W-1:0]    req_payload_byte,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [BYTE_W-1:0]    csr_data,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output logic [BYTE_W-1:0]    rsp_line_byte,
   output logic                 rsp_frame_done,
   input  cmd_type              cmd,
   output status_type           st
);

   localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);
   localparam int IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
   localparam logic [CNT_W-1:0] CNT_MAX    = CNT_W'(MAX_PAYLOAD);
   localparam logic [CNT_W-1:0] CNT_ALMOST = CNT_W'(MAX_PAYLOAD - 1);

   logic [BYTE_W-1:0] start_sym_ff, start_sym_in;
   logic [BYTE_W-1:0] esc_sym_ff, esc_sym_in;
   logic [BYTE_W-1:0] end_sym_ff, end_sym_in;
   logic [BYTE_W-1:0] store_ff [MAX_PAYLOAD];
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              ovf_ff, ovf_in;
   logic [BYTE_W-1:0] sum_ff, sum_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              esc_ff, esc_in;
   logic              allres_ff, allres_in;
   logic              out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0] out_byte_ff, out_byte_in;
   logic              out_done_ff, out_done_in;

   logic [BYTE_W-1:0] cur_byte;
   logic              store_we;

   assign cur_byte = store_ff[idx_ff];
   assign store_we = cmd.accept && (count_ff != CNT_MAX);

   always_comb begin
      start_sym_in = start_sym_ff;
      esc_sym_in   = esc_sym_ff;
      end_sym_in   = end_sym_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_START_SYMBOL:  start_sym_in = csr_data;
            CSR_ESCAPE_SYMBOL: esc_sym_in   = csr_data;
            CSR_END_SYMBOL:    end_sym_in   = csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      count_in  = count_ff;
      ovf_in    = ovf_ff;
      sum_in    = sum_ff;
      idx_in    = idx_ff;
      esc_in    = esc_ff;
      allres_in = allres_ff;
      if (store_we) begin
         count_in = count_ff + 1'b1;
         sum_in   = sum_ff + req_payload_byte;
      end else if (cmd.accept) begin
         ovf_in = 1'b1;
      end
      if (cmd.frame_clear) begin
         count_in = '0;
         ovf_in   = 1'b0;
         sum_in   = '0;
      end
      if (cmd.scan_step) begin
         allres_in = allres_ff && st.cur_res;
      end
      if (cmd.idx_clear) begin
         idx_in    = '0;
         allres_in = 1'b1;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + 1'b1;
      end
      if (cmd.esc_set) begin
         esc_in = 1'b1;
      end else if (cmd.esc_clear) begin
         esc_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff && !rsp_ready;
      out_byte_in  = out_byte_ff;
      out_done_in  = out_done_ff;
      if (cmd.push) begin
         out_valid_in = 1'b1;
         out_done_in  = 1'b0;
         unique case (cmd.push_sel)
            SEL_START:  out_byte_in = start_sym_ff;
            SEL_ESCAPE: out_byte_in = esc_sym_ff;
            SEL_DATA:   out_byte_in = cur_byte;
            SEL_SUM:    out_byte_in = sum_ff;
            SEL_END: begin
               out_byte_in = end_sym_ff;
               out_done_in = 1'b1;
            end
            default:    out_byte_in = out_byte_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_sym_ff <= START_SYMBOL_RST;
         esc_sym_ff   <= ESCAPE_SYMBOL_RST;
         end_sym_ff   <= END_SYMBOL_RST;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         sum_ff       <= '0;
         idx_ff       <= '0;
         esc_ff       <= 1'b0;
         allres_ff    <= 1'b1;
         out_valid_ff <= 1'b0;
      end else begin
         start_sym_ff <= start_sym_in;
         esc_sym_ff   <= esc_sym_in;
         end_sym_ff   <= end_sym_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         sum_ff       <= sum_in;
         idx_ff       <= idx_in;
         esc_ff       <= esc_in;
         allres_ff    <= allres_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_byte_ff <= out_byte_in;
      out_done_ff <= out_done_in;
      if (store_we) begin
         store_ff[count_ff[IDX_W-1:0]] <= req_payload_byte;
      end
   end

   assign st.full        = (count_ff == CNT_MAX);
   assign st.almost_full = (count_ff == CNT_ALMOST);
   assign st.ovf         = ovf_ff;
   assign st.last_idx    = (CNT_W'(idx_ff) == (count_ff - 1'b1));
   assign st.cur_res     = is_reserved(cur_byte, start_sym_ff, esc_sym_ff, end_sym_ff);
   assign st.sum_res     = is_reserved(sum_ff, start_sym_ff, esc_sym_ff, end_sym_ff);
   assign st.all_res     = allres_ff;
   assign st.esc         = esc_ff;
   assign st.out_free    = !out_valid_ff || rsp_ready;

   assign rsp_valid      = out_valid_ff;
   assign rsp_line_byte  = out_byte_ff;
   assign rsp_frame_done = out_done_ff;

endmodule

FILE: hdl/escaped_frame_encoder_checksum.sv
// ----------------------------------------------------------------------------
// escaped_frame_encoder_checksum: byte-stuffing frame encoder with checksum
// Payload words are taken one per cycle into an internal store of
// MAX_PAYLOAD entries. The word marked last starts emission: start symbol,
// each payload byte (escaped when it matches any symbol), the 8-bit sum
// (escaped the same way) and the end symbol, one line word per cycle while
// the output is taken. A frame of exactly MAX_PAYLOAD bytes first runs a
// check pass over the store, since such a frame is dropped when every byte
// and the sum need escaping. Overlong frames are dropped with no output.
// Input is not taken during check and emission. Symbols are written through
// the csr_ port (index 0 start, 1 escape, 2 end); the user must write them
// only while idle, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
module escaped_frame_encoder_checksum
   import efe_pkg::*;
#(
   parameter int MAX_PAYLOAD = 8
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [BYTE_W-1:0]    req_payload_byte,
   input  logic                 req_payload_last,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [BYTE_W-1:0]    rsp_line_byte,
   output logic                 rsp_frame_done,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [BYTE_W-1:0]    csr_data
);

   cmd_type    cmd;
   status_type st;

   assign csr_ready = 1'b1;

   efe_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_payload_last (req_payload_last),
      .req_ready        (req_ready),
      .st               (st),
      .cmd              (cmd)
   );

   efe_dp #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_payload_byte (req_payload_byte),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_line_byte    (rsp_line_byte),
      .rsp_frame_done   (rsp_frame_done),
      .cmd              (cmd),
      .st               (st)
   );

`ifndef NO_ASSERTIONS
   // never overwrite a word still waiting at the output
   a_push_free: assert property (@(posedge clock) disable iff (reset)
      cmd.push |-> st.out_free)
      else $error("push while output word pending");

   // a reserved payload byte goes out only after its escape
   a_data_escaped: assert property (@(posedge clock) disable iff (reset)
      (cmd.push && cmd.push_sel == SEL_DATA && st.cur_res) |-> st.esc)
      else $error("reserved byte sent unescaped");

   // frame state is cleared on output only with the end symbol
   a_clear_on_end: assert property (@(posedge clock) disable iff (reset)
      (cmd.push && cmd.frame_clear) |-> cmd.push_sel == SEL_END)
      else $error("frame cleared mid-emission");

   // end word leaves the block ready for a new frame
   a_end_ready: assert property (@(posedge clock) disable iff (reset)
      (cmd.push && cmd.push_sel == SEL_END) |=> req_ready)
      else $error("not collecting after end symbol");
`endif

endmodule
